/* rtl/mexp_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, reset value and handshake structs for the modular exponentiation block.
// Depends on nothing; every other file imports it.
package mexp_pkg;

    localparam int MOD_W        = 31;
    localparam int IN_W         = 63;
    localparam int EXP_BITS_DEF = 63;
    localparam int CNT_W        = 7;
    localparam int S_TDATA_W    = 128;
    localparam int M_TDATA_W    = 32;

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(100000007);
    localparam logic [CNT_W-1:0] LEN_MUL   = CNT_W'(MOD_W);
    localparam logic [CNT_W-1:0] LEN_RED   = CNT_W'(IN_W);

    // Command to the bit-serial modular unit.
    typedef struct packed {
        logic             start;
        logic             reduce;
        logic [MOD_W-1:0] x;
        logic [IN_W-1:0]  opnd;
        logic [CNT_W-1:0] len;
    } mod_cmd_t;

    // Status back from the unit.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MOD_W-1:0] result;
    } mod_sts_t;

endpackage

/* rtl/mexp_mod_unit.sv */
`timescale 1ns / 1ps
// Bit-serial modular unit: one operand bit per cycle, either x*y mod m or a wide value mod m.
// Depends on mexp_pkg.
module mexp_mod_unit
    import mexp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [MOD_W-1:0] modulus,
    input  mod_cmd_t         cmd,
    output mod_sts_t         sts
);

    logic [MOD_W-1:0] acc_reg, acc_next;
    logic [IN_W-1:0]  sh_reg, sh_next;
    logic [MOD_W-1:0] x_reg, x_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             reduce_reg, reduce_next;

    logic [MOD_W:0]   dbl;
    logic [MOD_W-1:0] dbl_red;
    logic [MOD_W:0]   sum;
    logic [MOD_W-1:0] sum_red;
    logic             top_bit;

    assign top_bit = sh_reg[IN_W-1];

    always_comb begin
        dbl     = {acc_reg, reduce_reg & top_bit};
        dbl_red = (dbl >= {1'b0, modulus}) ? MOD_W'(dbl - {1'b0, modulus}) : dbl[MOD_W-1:0];
        sum     = {1'b0, dbl_red} + {1'b0, x_reg};
        if (!reduce_reg && top_bit) begin
            sum_red = (sum >= {1'b0, modulus}) ? MOD_W'(sum - {1'b0, modulus})
                                               : sum[MOD_W-1:0];
        end else begin
            sum_red = dbl_red;
        end
    end

    always_comb begin
        acc_next    = acc_reg;
        sh_next     = sh_reg;
        x_next      = x_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        reduce_next = reduce_reg;
        done_next   = 1'b0;
        if (busy_reg) begin
            acc_next = sum_red;
            sh_next  = {sh_reg[IN_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (cmd.start) begin
            acc_next    = '0;
            sh_next     = cmd.opnd;
            x_next      = cmd.x;
            cnt_next    = cmd.len;
            reduce_next = cmd.reduce;
            busy_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg    <= acc_next;
        sh_reg     <= sh_next;
        x_reg      <= x_next;
        cnt_reg    <= cnt_next;
        reduce_reg <= reduce_next;
    end

    assign sts.busy   = busy_reg;
    assign sts.done   = done_reg;
    assign sts.result = acc_reg;

endmodule

/* rtl/mexp_seq.sv */
`timescale 1ns / 1ps
// Square-and-multiply sequencer with input handshake and registered output.
// Depends on mexp_pkg; drives one mexp_mod_unit through its command struct.
module mexp_seq
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [MOD_W-1:0] modulus,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [IN_W-1:0]  in_base,
    input  logic [IN_W-1:0]  in_exponent,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [MOD_W-1:0] out_power,
    output mod_cmd_t         cmd,
    input  mod_sts_t         sts
);

    localparam int BITS_W = $clog2(EXP_BITS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RED   = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_SQR   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [BITS_W-1:0]   bits_reg, bits_next;
    logic [MOD_W-1:0]    b_reg, b_next;
    logic [MOD_W-1:0]    r_reg, r_next;
    logic [MOD_W-1:0]    out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic                load_out;
    logic                last_bit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign last_bit  = (bits_reg == BITS_W'(1));
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb begin
        state_next = state_reg;
        exp_next   = exp_reg;
        bits_next  = bits_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    exp_next  = in_exponent[EXP_BITS-1:0];
                    bits_next = BITS_W'(EXP_BITS);
                    if (in_exponent[EXP_BITS-1:0] == '0) begin
                        r_next     = MOD_W'(1);
                        state_next = ST_DONE;
                    end else begin
                        cmd.start  = 1'b1;
                        cmd.reduce = 1'b1;
                        cmd.opnd   = in_base;
                        cmd.len    = LEN_RED;
                        state_next = ST_RED;
                    end
                end
            end
            ST_RED: begin
                if (sts.done) begin
                    b_next     = sts.result;
                    r_next     = (modulus == MOD_W'(1)) ? '0 : MOD_W'(1);
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.start  = 1'b1;
                cmd.x      = r_reg;
                cmd.opnd   = {r_reg, (IN_W - MOD_W)'(0)};
                cmd.len    = LEN_MUL;
                state_next = ST_SQR;
            end
            ST_SQR: begin
                if (sts.done) begin
                    r_next = sts.result;
                    if (exp_reg[EXP_BITS-1]) begin
                        cmd.start  = 1'b1;
                        cmd.x      = b_reg;
                        cmd.opnd   = {sts.result, (IN_W - MOD_W)'(0)};
                        cmd.len    = LEN_MUL;
                        state_next = ST_MUL;
                    end else begin
                        exp_next   = exp_reg << 1;
                        bits_next  = bits_reg - BITS_W'(1);
                        state_next = last_bit ? ST_DONE : ST_ISSUE;
                    end
                end
            end
            ST_MUL: begin
                if (sts.done) begin
                    r_next     = sts.result;
                    exp_next   = exp_reg << 1;
                    bits_next  = bits_reg - BITS_W'(1);
                    state_next = last_bit ? ST_DONE : ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_next       = load_out ? r_reg : out_reg;
        out_valid_next = load_out | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        exp_reg  <= exp_next;
        bits_reg <= bits_next;
        b_reg    <= b_next;
        r_reg    <= r_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_power = out_reg;

endmodule

/* rtl/modular_exponentiation_unit.sv */
`timescale 1ns / 1ps
// Top level of the modular exponentiation block: stream ports, modulus register.
// Depends on mexp_pkg, mexp_mod_unit and mexp_seq.
//
//  Channel  | Direction | Handshake               | Contents
//  s_       | in        | s_tvalid / s_tready     | base, exponent
//  m_       | out       | m_tvalid / m_tready     | power
//  cfg_     | in        | cfg_valid / cfg_ready   | modulus
//
// An item with a zero exponent goes straight to the result register. Otherwise the base is
// first reduced modulo the modulus, and each of the EXP_BITS exponent bits, from the top,
// takes a modular square plus, on a one bit, a modular multiply; the result is then handed
// over to the result register. The serial modular unit does the arithmetic, one multiplier
// bit per cycle.
// Reset restores the modulus to 100000007 and empties the result register.
// A stalled result register does not block the next item from being accepted.
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [62:0] base, [125:63] exponent, [127:126] unused
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [30:0] power, [31] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MOD_W-1:0]     cfg_data
);

    logic [MOD_W-1:0] modulus_reg, modulus_next;
    logic [MOD_W-1:0] modulus_eff;
    logic [MOD_W-1:0] power;
    mod_cmd_t         cmd;
    mod_sts_t         sts;

    assign cfg_ready    = 1'b1;
    assign modulus_next = cfg_valid ? cfg_data : modulus_reg;
    // A zero modulus behaves as a modulus of one.
    assign modulus_eff  = (modulus_reg == '0) ? MOD_W'(1) : modulus_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MOD_RESET;
        end else begin
            modulus_reg <= modulus_next;
        end
    end

    mexp_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .modulus (modulus_eff),
        .cmd     (cmd),
        .sts     (sts)
    );

    mexp_seq #(
        .EXP_BITS (EXP_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .modulus     (modulus_eff),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_base     (s_tdata[IN_W-1:0]),
        .in_exponent (s_tdata[2*IN_W-1:IN_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_power   (power),
        .cmd         (cmd),
        .sts         (sts)
    );

    assign m_tdata = {(M_TDATA_W - MOD_W)'(0), power};

endmodule
